### rtl/assert_macros.svh
// Assertion macros shared by the UDP receive checker modules (clk / rst_n domain).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must never hold outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/urc_pkg.sv
// Types, constants and helpers for the UDP receive checker.
`timescale 1ns / 1ps
`default_nettype none

package urc_pkg;

    // Verdict codes
    localparam logic [2:0] VERDICT_ECHO     = 3'd0;
    localparam logic [2:0] VERDICT_UNREACH  = 3'd1;
    localparam logic [2:0] VERDICT_RUNT     = 3'd2;
    localparam logic [2:0] VERDICT_BAD_LEN  = 3'd3;
    localparam logic [2:0] VERDICT_BAD_CSUM = 3'd4;

    localparam logic [15:0] HDR_BYTES       = 16'd8;
    localparam logic [15:0] PROTO_UDP       = 16'd17;
    localparam logic [15:0] ECHO_PORT_RESET = 16'd7;
    localparam logic [15:0] COUNT_MAX       = 16'hFFFF;
    localparam logic [16:0] CSUM_GOOD       = 17'h0FFFF;

    // Header byte positions
    localparam logic [15:0] IDX_SPORT_HI = 16'd0;
    localparam logic [15:0] IDX_SPORT_LO = 16'd1;
    localparam logic [15:0] IDX_DPORT_HI = 16'd2;
    localparam logic [15:0] IDX_DPORT_LO = 16'd3;
    localparam logic [15:0] IDX_LEN_HI   = 16'd4;
    localparam logic [15:0] IDX_LEN_LO   = 16'd5;
    localparam logic [15:0] IDX_CSUM_HI  = 16'd6;
    localparam logic [15:0] IDX_CSUM_LO  = 16'd7;

    typedef struct packed {
        logic [7:0]  seg_byte;
        logic        seg_last;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
    } seg_in_t;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [15:0] payload_length;
    } seg_result_t;

    // Per-segment record handed from the front to the back
    typedef struct packed {
        logic [15:0] avail;
        logic [15:0] ulen;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [15:0] csum;
        logic [15:0] sum;
        logic [7:0]  hold;
        logic [63:0] addrs;
    } seg_summary_t;

    // 16-bit ones' complement add with end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

`default_nettype wire

### rtl/urc_fifo.sv
// Small flip-flop queue used between the checker stages.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module urc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    `ASSERT_NEVER(a_cnt_range, cnt_reg > CNT_W'(DEPTH), "queue count above depth")
    `ASSERT_NEXT(a_cnt_inc, do_push && !do_pop, cnt_reg == $past(cnt_reg) + 1'b1, "queue count did not grow on push")

endmodule

`default_nettype wire

### rtl/urc_front.sv
// Front end: takes segment bytes, latches the header, keeps the running sum.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module urc_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  accept,
    input  wire urc_pkg::seg_in_t      item,
    output logic                       sum_push,
    output urc_pkg::seg_summary_t      summary
);

    logic [15:0] byte_count_reg, byte_count_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  hold_reg, hold_next;
    logic [15:0] sport_reg, sport_next;
    logic [15:0] dport_reg, dport_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] csum_reg, csum_next;
    logic [63:0] addrs_reg, addrs_next;
    logic [7:0]  b;

    assign b = item.seg_byte;

    always_comb
    begin
        addrs_next = (byte_count_reg == '0) ? {item.src_addr, item.dst_addr} : addrs_reg;
        sport_next = sport_reg;
        dport_next = dport_reg;
        len_next   = len_reg;
        csum_next  = csum_reg;
        case (byte_count_reg)
            urc_pkg::IDX_SPORT_HI: sport_next = {b, sport_reg[7:0]};
            urc_pkg::IDX_SPORT_LO: sport_next = {sport_reg[15:8], b};
            urc_pkg::IDX_DPORT_HI: dport_next = {b, dport_reg[7:0]};
            urc_pkg::IDX_DPORT_LO: dport_next = {dport_reg[15:8], b};
            urc_pkg::IDX_LEN_HI:   len_next   = {b, len_reg[7:0]};
            urc_pkg::IDX_LEN_LO:   len_next   = {len_reg[15:8], b};
            urc_pkg::IDX_CSUM_HI:  csum_next  = {b, csum_reg[7:0]};
            urc_pkg::IDX_CSUM_LO:  csum_next  = {csum_reg[15:8], b};
            default: ;
        endcase

        // only header bytes and bytes within the length field are summed
        hold_next = hold_reg;
        sum_next  = sum_reg;
        if (byte_count_reg < urc_pkg::HDR_BYTES || byte_count_reg < len_reg)
        begin
            if (!byte_count_reg[0])
            begin
                hold_next = b;
            end
            else
            begin
                sum_next = urc_pkg::oc_add(sum_reg, {hold_reg, b});
            end
        end

        byte_count_next = (byte_count_reg == urc_pkg::COUNT_MAX) ? byte_count_reg
                                                                 : byte_count_reg + 1'b1;
    end

    assign sum_push      = accept && item.seg_last;
    assign summary.avail = byte_count_next;
    assign summary.ulen  = len_next;
    assign summary.sport = sport_next;
    assign summary.dport = dport_next;
    assign summary.csum  = csum_next;
    assign summary.sum   = sum_next;
    assign summary.hold  = hold_next;
    assign summary.addrs = addrs_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            sum_reg        <= '0;
            hold_reg       <= '0;
            sport_reg      <= '0;
            dport_reg      <= '0;
            len_reg        <= '0;
            csum_reg       <= '0;
            addrs_reg      <= '0;
        end
        else if (accept)
        begin
            addrs_reg <= addrs_next;
            if (item.seg_last)
            begin
                byte_count_reg <= '0;
                sum_reg        <= '0;
                hold_reg       <= '0;
                sport_reg      <= '0;
                dport_reg      <= '0;
                len_reg        <= '0;
                csum_reg       <= '0;
            end
            else
            begin
                byte_count_reg <= byte_count_next;
                sum_reg        <= sum_next;
                hold_reg       <= hold_next;
                sport_reg      <= sport_next;
                dport_reg      <= dport_next;
                len_reg        <= len_next;
                csum_reg       <= csum_next;
            end
        end
    end

    `ASSERT_NEXT(a_clear_after_last, accept && item.seg_last, byte_count_reg == '0 && sum_reg == '0, "segment state not cleared")
    `ASSERT_NEXT(a_count_step, accept && !item.seg_last && byte_count_reg != urc_pkg::COUNT_MAX, byte_count_reg == $past(byte_count_reg) + 1'b1, "byte count did not advance")

endmodule

`default_nettype wire

### rtl/urc_back.sv
// Back end: finishes the checksum and forms the verdict for each segment.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module urc_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [15:0]           echo_port,
    input  wire urc_pkg::seg_summary_t summary,
    input  wire logic                  sum_empty,
    output logic                       sum_pop,
    output logic                       res_push,
    input  wire logic                  res_full,
    output urc_pkg::seg_result_t       result
);

    logic        s1_vld_reg;
    logic        s1_runt_reg, s1_badlen_reg, s1_csum_nz_reg;
    logic [17:0] s1_psum_a_reg, s1_psum_b_reg;
    logic [15:0] s1_sport_reg, s1_dport_reg, s1_plen_reg;

    logic        s1_ready;
    logic [15:0] pad;
    logic [17:0] psum_a, psum_b;
    logic [18:0] total;
    logic [16:0] folded;
    logic        sum_ok;

    assign s1_ready = !s1_vld_reg || !res_full;
    assign sum_pop  = !sum_empty && s1_ready;
    assign res_push = s1_vld_reg && !res_full;

    // pseudo-header plus segment sum, split in two halves
    assign pad    = summary.ulen[0] ? {summary.hold, 8'h00} : 16'h0000;
    assign psum_a = {2'b00, summary.sum} + {2'b00, pad}
                  + {2'b00, summary.addrs[63:48]} + {2'b00, summary.addrs[47:32]};
    assign psum_b = {2'b00, summary.addrs[31:16]} + {2'b00, summary.addrs[15:0]}
                  + {2'b00, urc_pkg::PROTO_UDP} + {2'b00, summary.ulen};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_vld_reg <= !sum_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_pop)
        begin
            s1_runt_reg    <= summary.avail < urc_pkg::HDR_BYTES;
            s1_badlen_reg  <= summary.ulen < urc_pkg::HDR_BYTES || summary.ulen > summary.avail;
            s1_csum_nz_reg <= summary.csum != '0;
            s1_psum_a_reg  <= psum_a;
            s1_psum_b_reg  <= psum_b;
            s1_sport_reg   <= summary.sport;
            s1_dport_reg   <= summary.dport;
            s1_plen_reg    <= summary.ulen - urc_pkg::HDR_BYTES;
        end
    end

    // nonzero terms: the folded sum is all ones exactly when the check passes
    assign total  = {1'b0, s1_psum_a_reg} + {1'b0, s1_psum_b_reg};
    assign folded = {1'b0, total[15:0]} + {14'd0, total[18:16]};
    assign sum_ok = folded == urc_pkg::CSUM_GOOD;

    always_comb
    begin
        result.source_port    = s1_sport_reg;
        result.dest_port      = s1_dport_reg;
        result.payload_length = '0;
        if (s1_runt_reg)
        begin
            result.verdict     = urc_pkg::VERDICT_RUNT;
            result.source_port = '0;
            result.dest_port   = '0;
        end
        else if (s1_badlen_reg)
        begin
            result.verdict = urc_pkg::VERDICT_BAD_LEN;
        end
        else if (s1_csum_nz_reg && !sum_ok)
        begin
            result.verdict = urc_pkg::VERDICT_BAD_CSUM;
        end
        else
        begin
            result.verdict        = (s1_dport_reg == echo_port) ? urc_pkg::VERDICT_ECHO
                                                                : urc_pkg::VERDICT_UNREACH;
            result.payload_length = s1_plen_reg;
        end
    end

    `ASSERT_NEXT(a_hold_on_stall, s1_vld_reg && res_full, s1_vld_reg && $stable(s1_sport_reg) && $stable(s1_psum_a_reg), "finisher lost a stalled segment")
    `ASSERT_IMPLIES(a_runt_zero, s1_vld_reg && s1_runt_reg, result.source_port == '0 && result.payload_length == '0, "runt verdict carries header data")

endmodule

`default_nettype wire

### rtl/udp_receive_checker.sv
// Top level of the UDP receive checker: front end, segment queue, finisher, result queue.
`timescale 1ns / 1ps
`default_nettype none

// UDP receive checker. Segment bytes enter on the push/full queue port, with the IPv4
// addresses sampled on the first byte of each segment; a byte with seg_last set closes
// the segment and yields exactly one verdict (echo deliver, port unreachable, runt, bad
// length or bad checksum) together with the header ports (zero for a runt) and payload
// length (zero unless echo deliver or port unreachable). Throughput is one byte per
// cycle while full is low, including back-to-back one-byte segments. The front end
// keeps the running 16-bit ones' complement sum and header fields; at the last byte it
// hands a segment record to a SEG_QUEUE_DEPTH-entry queue, the finisher folds in the
// pseudo-header and decides in one register stage, and results wait in a
// RESULT_QUEUE_DEPTH-entry queue. A verdict passes through the segment queue, the
// finisher register and the result queue before it is visible on the result port. full
// rises only when SEG_QUEUE_DEPTH closed segments are still waiting for the finisher,
// which in turn waits only on a full result queue. echo_port resets to 7 and is written
// through cfg_we/cfg_wdata; the user must do so only while the block is idle, unenforced.

module udp_receive_checker #(
    parameter int SEG_QUEUE_DEPTH    = 2,
    parameter int RESULT_QUEUE_DEPTH = 2
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // segment byte input
    input  wire logic                 push,
    output logic                      full,
    input  wire urc_pkg::seg_in_t     item,
    // verdict output
    output logic                      empty,
    input  wire logic                 pop,
    output urc_pkg::seg_result_t      result,
    // echo port register
    input  wire logic                 cfg_we,
    input  wire logic [15:0]          cfg_wdata
);

    localparam int SUM_W = $bits(urc_pkg::seg_summary_t);
    localparam int RES_W = $bits(urc_pkg::seg_result_t);

    logic                  accept;
    logic                  sum_push, sum_pop, sum_empty;
    urc_pkg::seg_summary_t sum_wdata, sum_rdata;
    logic                  res_push, res_full;
    urc_pkg::seg_result_t  res_wdata;
    logic [15:0]           echo_port_reg;

    // a byte transfer happens whenever the segment queue has room
    assign accept = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_port_reg <= urc_pkg::ECHO_PORT_RESET;
        end
        else if (cfg_we)
        begin
            echo_port_reg <= cfg_wdata;
        end
    end

    urc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .sum_push (sum_push),
        .summary  (sum_wdata)
    );

    // closed segments waiting for the finisher
    urc_fifo #(
        .WIDTH (SUM_W),
        .DEPTH (SEG_QUEUE_DEPTH)
    ) u_seg_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (sum_push),
        .wdata (sum_wdata),
        .full  (full),
        .pop   (sum_pop),
        .rdata (sum_rdata),
        .empty (sum_empty)
    );

    urc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .echo_port (echo_port_reg),
        .summary   (sum_rdata),
        .sum_empty (sum_empty),
        .sum_pop   (sum_pop),
        .res_push  (res_push),
        .res_full  (res_full),
        .result    (res_wdata)
    );

    // verdicts waiting to be popped
    urc_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RESULT_QUEUE_DEPTH)
    ) u_result_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_wdata),
        .full  (res_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

endmodule

`default_nettype wire
